### hdl/cpu8ex_pkg.sv
// ----------------------------------------------------------------------------
// cpu8ex_pkg
// Shared types and constants of the 8-bit execute stage: operation codes,
// status flag positions, register reset values and the state/result records.
// ----------------------------------------------------------------------------
package cpu8ex_pkg;

    typedef enum logic [5:0] {
        OP_ADC     = 6'd0,
        OP_SBC     = 6'd1,
        OP_AND     = 6'd2,
        OP_ORA     = 6'd3,
        OP_EOR     = 6'd4,
        OP_CMP     = 6'd5,
        OP_CPX     = 6'd6,
        OP_CPY     = 6'd7,
        OP_BIT     = 6'd8,
        OP_ASL_A   = 6'd9,
        OP_ASL_MEM = 6'd10,
        OP_LDA     = 6'd11,
        OP_LDX     = 6'd12,
        OP_LDY     = 6'd13,
        OP_STA     = 6'd14,
        OP_STX     = 6'd15,
        OP_STY     = 6'd16,
        OP_TAX     = 6'd17,
        OP_TAY     = 6'd18,
        OP_TXA     = 6'd19,
        OP_TYA     = 6'd20,
        OP_TSX     = 6'd21,
        OP_TXS     = 6'd22,
        OP_INX     = 6'd23,
        OP_INY     = 6'd24,
        OP_DEX     = 6'd25,
        OP_DEY     = 6'd26,
        OP_CLC     = 6'd27,
        OP_SEC     = 6'd28,
        OP_CLI     = 6'd29,
        OP_SEI     = 6'd30,
        OP_CLD     = 6'd31,
        OP_SED     = 6'd32,
        OP_CLV     = 6'd33,
        OP_PHA     = 6'd34,
        OP_PHP     = 6'd35,
        OP_PLA     = 6'd36,
        OP_PLP     = 6'd37,
        OP_BPL     = 6'd38,
        OP_BMI     = 6'd39,
        OP_BVC     = 6'd40,
        OP_BVS     = 6'd41,
        OP_BCC     = 6'd42,
        OP_BCS     = 6'd43,
        OP_BNE     = 6'd44,
        OP_BEQ     = 6'd45
    } op_t;

    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_B = 4;
    localparam int unsigned FLAG_U = 5;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h20;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } arch_state_t;

    typedef struct packed {
        logic [7:0] write_data;
        logic       write_enable;
        logic [7:0] stack_slot;
        logic [7:0] status_out;
        logic       branch_taken;
    } result_t;

endpackage

### hdl/cpu8ex_alu.sv
// ----------------------------------------------------------------------------
// cpu8ex_alu
// Single-pass execute logic: from the current registers, one operation and
// its operand byte, forms the next register values and the result item.
// ----------------------------------------------------------------------------
module cpu8ex_alu
    import cpu8ex_pkg::*;
(
    input  logic [5:0]  op,
    input  logic [7:0]  operand,
    input  logic        decimal_enable,
    input  arch_state_t state_cur,
    output arch_state_t state_next,
    output result_t     result_next
);

    function automatic logic [7:0] with_zn(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] r;
        r         = p;
        r[FLAG_Z] = (v == 8'h00);
        r[FLAG_N] = v[7];
        return r;
    endfunction

    logic       bcd;
    logic       cin;
    logic [8:0] adc_sum;
    logic [8:0] sbc_sum;
    logic [7:0] inv;
    logic [4:0] adc_lo5;
    logic       adc_dc0;
    logic [4:0] adc_hi5;
    logic       adc_dc1;
    logic [3:0] adc_lo;
    logic [3:0] adc_hi;
    logic [4:0] sbc_lo5;
    logic [4:0] sbc_hi5;
    logic [3:0] sbc_lo;
    logic [3:0] sbc_hi;
    logic       sbc_neg;

    assign bcd = decimal_enable & state_cur.p[FLAG_D];
    assign cin = state_cur.p[FLAG_C];
    assign inv = ~operand;

    assign adc_sum = {1'b0, state_cur.a} + {1'b0, operand} + {8'd0, cin};
    assign sbc_sum = {1'b0, state_cur.a} + {1'b0, inv} + {8'd0, cin};

    assign adc_lo5 = {1'b0, state_cur.a[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin};
    assign adc_dc0 = (adc_lo5 > 5'd9);
    assign adc_lo  = adc_dc0 ? 4'(adc_lo5 - 5'd10) : adc_lo5[3:0];
    assign adc_hi5 = {1'b0, state_cur.a[7:4]} + {1'b0, operand[7:4]} + {4'd0, adc_dc0};
    assign adc_dc1 = (adc_hi5 > 5'd9);
    assign adc_hi  = adc_dc1 ? 4'(adc_hi5 - 5'd10) : adc_hi5[3:0];

    assign sbc_neg = sbc_sum[7];
    assign sbc_lo5 = {1'b0, state_cur.a[3:0]} - {1'b0, operand[3:0]} - {4'd0, ~cin};
    assign sbc_lo  = sbc_lo5[4] ? 4'(sbc_lo5 + 5'd10) : sbc_lo5[3:0];
    assign sbc_hi5 = {1'b0, state_cur.a[7:4]} - {1'b0, operand[7:4]} - {4'd0, sbc_lo5[4]};
    assign sbc_hi  = sbc_hi5[4] ? 4'(sbc_hi5 + 5'd10) : sbc_hi5[3:0];

    always_comb begin
        arch_state_t nxt;
        logic        we;
        logic        br;
        logic        slot_set;
        logic [7:0]  wd;
        logic [7:0]  slot;
        logic [7:0]  t;

        nxt      = state_cur;
        we       = 1'b0;
        br       = 1'b0;
        slot_set = 1'b0;
        wd       = 8'h00;
        slot     = 8'h00;
        t        = 8'h00;

        case (op_t'(op))
            OP_ADC: begin
                if (bcd) begin
                    nxt.a        = {adc_hi, adc_lo};
                    nxt.p[FLAG_N] = adc_hi5[3];
                    nxt.p[FLAG_V] = (state_cur.a[7] != adc_hi5[3]) &&
                                    (operand[7] != adc_hi5[3]);
                    nxt.p[FLAG_Z] = (adc_sum[7:0] == 8'h00);
                    nxt.p[FLAG_C] = adc_dc1;
                end else begin
                    nxt.a         = adc_sum[7:0];
                    nxt.p[FLAG_C] = adc_sum[8];
                    nxt.p[FLAG_V] = ~(state_cur.a[7] ^ operand[7]) &
                                    (state_cur.a[7] ^ adc_sum[7]);
                    nxt.p         = with_zn(nxt.p, adc_sum[7:0]);
                end
            end
            OP_SBC: begin
                if (bcd) begin
                    nxt.a         = {sbc_hi, sbc_lo};
                    nxt.p[FLAG_N] = sbc_neg;
                    nxt.p[FLAG_V] = (state_cur.a[7] != sbc_neg) &&
                                    (!operand[7] != sbc_neg);
                    nxt.p[FLAG_Z] = (sbc_sum[7:0] == 8'h00);
                    nxt.p[FLAG_C] = ~sbc_hi5[4];
                end else begin
                    nxt.a         = sbc_sum[7:0];
                    nxt.p[FLAG_C] = sbc_sum[8];
                    nxt.p[FLAG_V] = (sbc_sum[7] ^ state_cur.a[7]) & (sbc_sum[7] ^ inv[7]);
                    nxt.p         = with_zn(nxt.p, sbc_sum[7:0]);
                end
            end
            OP_AND: begin
                nxt.a = state_cur.a & operand;
                nxt.p = with_zn(nxt.p, nxt.a);
            end
            OP_ORA: begin
                nxt.a = state_cur.a | operand;
                nxt.p = with_zn(nxt.p, nxt.a);
            end
            OP_EOR: begin
                nxt.a = state_cur.a ^ operand;
                nxt.p = with_zn(nxt.p, nxt.a);
            end
            OP_CMP: begin
                nxt.p[FLAG_C] = (state_cur.a >= operand);
                nxt.p         = with_zn(nxt.p, state_cur.a - operand);
            end
            OP_CPX: begin
                nxt.p[FLAG_C] = (state_cur.x >= operand);
                nxt.p         = with_zn(nxt.p, state_cur.x - operand);
            end
            OP_CPY: begin
                nxt.p[FLAG_C] = (state_cur.y >= operand);
                nxt.p         = with_zn(nxt.p, state_cur.y - operand);
            end
            OP_BIT: begin
                nxt.p[FLAG_Z] = ((state_cur.a & operand) == 8'h00);
                nxt.p[FLAG_V] = operand[6];
                nxt.p[FLAG_N] = operand[7];
            end
            OP_ASL_A: begin
                nxt.p[FLAG_C] = state_cur.a[7];
                nxt.a         = {state_cur.a[6:0], 1'b0};
                nxt.p         = with_zn(nxt.p, nxt.a);
            end
            OP_ASL_MEM: begin
                t             = {operand[6:0], 1'b0};
                nxt.p[FLAG_C] = operand[7];
                nxt.p         = with_zn(nxt.p, t);
                wd            = t;
                we            = 1'b1;
            end
            OP_LDA: begin
                nxt.a = operand;
                nxt.p = with_zn(nxt.p, operand);
            end
            OP_LDX: begin
                nxt.x = operand;
                nxt.p = with_zn(nxt.p, operand);
            end
            OP_LDY: begin
                nxt.y = operand;
                nxt.p = with_zn(nxt.p, operand);
            end
            OP_STA: begin
                wd = state_cur.a;
                we = 1'b1;
            end
            OP_STX: begin
                wd = state_cur.x;
                we = 1'b1;
            end
            OP_STY: begin
                wd = state_cur.y;
                we = 1'b1;
            end
            OP_TAX: begin
                nxt.x = state_cur.a;
                nxt.p = with_zn(nxt.p, state_cur.a);
            end
            OP_TAY: begin
                nxt.y = state_cur.a;
                nxt.p = with_zn(nxt.p, state_cur.a);
            end
            OP_TXA: begin
                nxt.a = state_cur.x;
                nxt.p = with_zn(nxt.p, state_cur.x);
            end
            OP_TYA: begin
                nxt.a = state_cur.y;
                nxt.p = with_zn(nxt.p, state_cur.y);
            end
            OP_TSX: begin
                nxt.x = state_cur.sp;
                nxt.p = with_zn(nxt.p, state_cur.sp);
            end
            OP_TXS: begin
                nxt.sp = state_cur.x;
            end
            OP_INX: begin
                nxt.x = state_cur.x + 8'd1;
                nxt.p = with_zn(nxt.p, nxt.x);
            end
            OP_INY: begin
                nxt.y = state_cur.y + 8'd1;
                nxt.p = with_zn(nxt.p, nxt.y);
            end
            OP_DEX: begin
                nxt.x = state_cur.x - 8'd1;
                nxt.p = with_zn(nxt.p, nxt.x);
            end
            OP_DEY: begin
                nxt.y = state_cur.y - 8'd1;
                nxt.p = with_zn(nxt.p, nxt.y);
            end
            OP_CLC: nxt.p[FLAG_C] = 1'b0;
            OP_SEC: nxt.p[FLAG_C] = 1'b1;
            OP_CLI: nxt.p[FLAG_I] = 1'b0;
            OP_SEI: nxt.p[FLAG_I] = 1'b1;
            OP_CLD: nxt.p[FLAG_D] = 1'b0;
            OP_SED: nxt.p[FLAG_D] = 1'b1;
            OP_CLV: nxt.p[FLAG_V] = 1'b0;
            OP_PHA, OP_PHP: begin
                if (op_t'(op) == OP_PHA) begin
                    wd = state_cur.a;
                end else begin
                    wd         = state_cur.p;
                    wd[FLAG_B] = 1'b1;
                    wd[FLAG_U] = 1'b1;
                end
                we       = 1'b1;
                slot     = state_cur.sp;
                slot_set = 1'b1;
                nxt.sp   = state_cur.sp - 8'd1;
            end
            OP_PLA, OP_PLP: begin
                nxt.sp   = state_cur.sp + 8'd1;
                slot     = nxt.sp;
                slot_set = 1'b1;
                if (op_t'(op) == OP_PLA) begin
                    nxt.a = operand;
                    nxt.p = with_zn(nxt.p, operand);
                end else begin
                    nxt.p         = operand;
                    nxt.p[FLAG_B] = 1'b0;
                    nxt.p[FLAG_U] = 1'b1;
                end
            end
            OP_BPL: br = ~state_cur.p[FLAG_N];
            OP_BMI: br = state_cur.p[FLAG_N];
            OP_BVC: br = ~state_cur.p[FLAG_V];
            OP_BVS: br = state_cur.p[FLAG_V];
            OP_BCC: br = ~state_cur.p[FLAG_C];
            OP_BCS: br = state_cur.p[FLAG_C];
            OP_BNE: br = ~state_cur.p[FLAG_Z];
            OP_BEQ: br = state_cur.p[FLAG_Z];
            default: begin
            end
        endcase

        state_next               = nxt;
        result_next.write_data   = we ? wd : nxt.a;
        result_next.write_enable = we;
        result_next.stack_slot   = slot_set ? slot : nxt.sp;
        result_next.status_out   = nxt.p;
        result_next.branch_taken = br;
    end

endmodule

### hdl/cpu_8bit_execute_stage.sv
// ----------------------------------------------------------------------------
// cpu_8bit_execute_stage
// Accumulator, index, stack pointer and status execute stage of an 8-bit CPU.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the result register is free or being
// taken (m_ready). An accepted item lands in an input register, the execute
// logic works on it and the processor registers, and the result waits in an
// output register until taken. The execute step updates A, X, Y, SP and P as
// the result is registered, so each item sees everything done by the items
// before it. decimal_enable is written through cfg_wr_en/cfg_wr_data and
// takes effect on the next item.
// ----------------------------------------------------------------------------
module cpu_8bit_execute_stage
    import cpu8ex_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [5:0] s_req_type,
    input  logic [7:0] s_operand,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_write_data,
    output logic       m_write_enable,
    output logic [7:0] m_stack_slot,
    output logic [7:0] m_status_out,
    output logic       m_branch_taken
);

    logic        dec_en_reg;
    logic        in_valid_reg;
    logic [5:0]  in_op_reg;
    logic [7:0]  in_operand_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    arch_state_t state_reg;
    arch_state_t state_next;
    logic        advance;

    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    cpu8ex_alu u_alu (
        .op             (in_op_reg),
        .operand        (in_operand_reg),
        .decimal_enable (dec_en_reg),
        .state_cur      (state_reg),
        .state_next     (state_next),
        .result_next    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            dec_en_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg      <= s_req_type;
            in_operand_reg <= s_operand;
        end
    end

    // processor registers: advance with each executed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.a  <= 8'h00;
            state_reg.x  <= 8'h00;
            state_reg.y  <= 8'h00;
            state_reg.sp <= SP_RESET;
            state_reg.p  <= STATUS_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_write_data   = result_reg.write_data;
    assign m_write_enable = result_reg.write_enable;
    assign m_stack_slot   = result_reg.stack_slot;
    assign m_status_out   = result_reg.status_out;
    assign m_branch_taken = result_reg.branch_taken;

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("processor registers changed without an executed item");

    a_push_sp: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_op_reg == OP_PHA || in_op_reg == OP_PHP)
        |=> state_reg.sp == $past(state_reg.sp) - 8'd1)
        else $error("push did not decrement the stack pointer");

    a_fixed_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.p[FLAG_U] && !state_reg.p[FLAG_B])
        else $error("status U/B bits corrupted");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid && m_status_out == state_reg.p)
        else $error("result status does not match processor status");

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cpu_8bit_execute_stage. A model of the
// A/X/Y/SP/P registers predicts every result as each item is accepted. The
// bench runs directed cases first, then random phases with idle sender and
// receiver and one long output hold. Every result is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
    import cpu8ex_pkg::*;

    localparam logic [5:0] FIRST_UNUSED_OP = 6'd46;
    localparam logic [5:0] LAST_UNUSED_OP  = 6'd63;
    localparam logic [7:0] OPERAND_CORNERS [5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       cfg_wr_en      = 1'b0;
    logic       cfg_wr_data    = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [5:0] s_req_type     = OP_ADC;
    logic [7:0] s_operand      = 8'h00;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_write_data;
    logic       m_write_enable;
    logic [7:0] m_stack_slot;
    logic [7:0] m_status_out;
    logic       m_branch_taken;

    arch_state_t arch;
    logic        dec_en;
    result_t     due_results [$];

    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int stall_cycles_left = 0;
    int items_sent        = 0;
    int results_checked   = 0;
    int mismatch_count    = 0;

    cpu_8bit_execute_stage dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_operand      (s_operand),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_data   (m_write_data),
        .m_write_enable (m_write_enable),
        .m_stack_slot   (m_stack_slot),
        .m_status_out   (m_status_out),
        .m_branch_taken (m_branch_taken)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void set_zn(input logic [7:0] v);
        arch.p[FLAG_Z] = (v == 8'h00);
        arch.p[FLAG_N] = v[7];
    endfunction

    function automatic void compare_with(input logic [7:0] r, input logic [7:0] m);
        logic [7:0] diff;
        diff = r - m;
        arch.p[FLAG_C] = (r >= m);
        set_zn(diff);
    endfunction

    function automatic void add_with_carry(input logic [7:0] m);
        int unsigned a, cin, sum, lo, hi;
        logic        neg, dc;
        a   = arch.a;
        cin = arch.p[FLAG_C];
        sum = a + m + cin;
        if (dec_en && arch.p[FLAG_D]) begin
            lo = (a & 15) + (m & 15) + cin;
            dc = (lo > 9);
            if (dc)
                lo = (lo - 10) & 15;
            hi = (a >> 4) + (m >> 4) + dc;
            neg = ((hi & 8) != 0);
            dc = (hi > 9);
            if (dc)
                hi = (hi - 10) & 15;
            arch.a = 8'(((hi & 15) << 4) | (lo & 15));
            arch.p[FLAG_N] = neg;
            arch.p[FLAG_V] = ((a >= 128) != neg) && ((m >= 128) != neg);
            arch.p[FLAG_Z] = ((sum & 255) == 0);
            arch.p[FLAG_C] = dc;
        end else begin
            arch.p[FLAG_C] = (sum > 255);
            arch.p[FLAG_V] = (((~(a ^ m)) & (a ^ sum) & 128) != 0);
            arch.a = 8'(sum);
            set_zn(arch.a);
        end
    endfunction

    function automatic void subtract_with_borrow(input logic [7:0] m);
        int unsigned a, cin, inv, sum;
        logic [7:0]  lo, hi;
        logic        neg, db;
        a   = arch.a;
        cin = arch.p[FLAG_C];
        inv = m ^ 8'hFF;
        sum = a + inv + cin;
        if (dec_en && arch.p[FLAG_D]) begin
            neg = ((sum & 128) != 0);
            lo = 8'((a & 15) - (m & 15) - (cin != 0 ? 0 : 1));
            db = (lo >= 8'h80);
            if (db)
                lo = (lo + 8'd10) & 8'h0F;
            hi = 8'((a >> 4) - (m >> 4) - db);
            db = (hi >= 8'h80);
            if (db)
                hi = (hi + 8'd10) & 8'h0F;
            arch.a = {hi[3:0], lo[3:0]};
            arch.p[FLAG_N] = neg;
            arch.p[FLAG_V] = ((a >= 128) != neg) && ((m < 128) != neg);
            arch.p[FLAG_Z] = ((sum & 255) == 0);
            arch.p[FLAG_C] = !db;
        end else begin
            arch.p[FLAG_C] = ((sum & 16'hFF00) != 0);
            arch.p[FLAG_V] = (((sum ^ a) & (sum ^ inv) & 128) != 0);
            arch.a = 8'(sum);
            set_zn(arch.a);
        end
    endfunction

    function automatic void execute_op(input logic [5:0] code, input logic [7:0] m,
                                       output result_t res);
        logic [7:0] wd, slot, t;
        logic       we, br, slot_set;
        wd = 8'h00;
        slot = 8'h00;
        we = 1'b0;
        br = 1'b0;
        slot_set = 1'b0;
        case (code)
            OP_ADC: add_with_carry(m);
            OP_SBC: subtract_with_borrow(m);
            OP_AND: begin arch.a = arch.a & m; set_zn(arch.a); end
            OP_ORA: begin arch.a = arch.a | m; set_zn(arch.a); end
            OP_EOR: begin arch.a = arch.a ^ m; set_zn(arch.a); end
            OP_CMP: compare_with(arch.a, m);
            OP_CPX: compare_with(arch.x, m);
            OP_CPY: compare_with(arch.y, m);
            OP_BIT: begin
                arch.p[FLAG_Z] = ((arch.a & m) == 8'h00);
                arch.p[FLAG_V] = m[6];
                arch.p[FLAG_N] = m[7];
            end
            OP_ASL_A, OP_ASL_MEM: begin
                t = (code == OP_ASL_A) ? arch.a : m;
                arch.p[FLAG_C] = t[7];
                t = t << 1;
                set_zn(t);
                if (code == OP_ASL_A) begin
                    arch.a = t;
                end else begin
                    wd = t;
                    we = 1'b1;
                end
            end
            OP_LDA: begin arch.a = m; set_zn(m); end
            OP_LDX: begin arch.x = m; set_zn(m); end
            OP_LDY: begin arch.y = m; set_zn(m); end
            OP_STA: begin wd = arch.a; we = 1'b1; end
            OP_STX: begin wd = arch.x; we = 1'b1; end
            OP_STY: begin wd = arch.y; we = 1'b1; end
            OP_TAX: begin arch.x = arch.a; set_zn(arch.x); end
            OP_TAY: begin arch.y = arch.a; set_zn(arch.y); end
            OP_TXA: begin arch.a = arch.x; set_zn(arch.a); end
            OP_TYA: begin arch.a = arch.y; set_zn(arch.a); end
            OP_TSX: begin arch.x = arch.sp; set_zn(arch.x); end
            OP_TXS: arch.sp = arch.x;
            OP_INX: begin arch.x = arch.x + 8'd1; set_zn(arch.x); end
            OP_INY: begin arch.y = arch.y + 8'd1; set_zn(arch.y); end
            OP_DEX: begin arch.x = arch.x - 8'd1; set_zn(arch.x); end
            OP_DEY: begin arch.y = arch.y - 8'd1; set_zn(arch.y); end
            OP_CLC: arch.p[FLAG_C] = 1'b0;
            OP_SEC: arch.p[FLAG_C] = 1'b1;
            OP_CLI: arch.p[FLAG_I] = 1'b0;
            OP_SEI: arch.p[FLAG_I] = 1'b1;
            OP_CLD: arch.p[FLAG_D] = 1'b0;
            OP_SED: arch.p[FLAG_D] = 1'b1;
            OP_CLV: arch.p[FLAG_V] = 1'b0;
            OP_PHA, OP_PHP: begin
                t = arch.p;
                t[FLAG_B] = 1'b1;
                t[FLAG_U] = 1'b1;
                wd = (code == OP_PHA) ? arch.a : t;
                we = 1'b1;
                slot = arch.sp;
                slot_set = 1'b1;
                arch.sp = arch.sp - 8'd1;
            end
            OP_PLA, OP_PLP: begin
                arch.sp = arch.sp + 8'd1;
                slot = arch.sp;
                slot_set = 1'b1;
                if (code == OP_PLA) begin
                    arch.a = m;
                    set_zn(m);
                end else begin
                    arch.p = m;
                    arch.p[FLAG_B] = 1'b0;
                    arch.p[FLAG_U] = 1'b1;
                end
            end
            OP_BPL: br = !arch.p[FLAG_N];
            OP_BMI: br = arch.p[FLAG_N];
            OP_BVC: br = !arch.p[FLAG_V];
            OP_BVS: br = arch.p[FLAG_V];
            OP_BCC: br = !arch.p[FLAG_C];
            OP_BCS: br = arch.p[FLAG_C];
            OP_BNE: br = !arch.p[FLAG_Z];
            OP_BEQ: br = arch.p[FLAG_Z];
            default: ;
        endcase
        res.write_data   = we ? wd : arch.a;
        res.write_enable = we;
        res.stack_slot   = slot_set ? slot : arch.sp;
        res.status_out   = arch.p;
        res.branch_taken = br;
    endfunction

    // hold the payload until accepted, then predict
    task automatic send_item(input logic [5:0] code, input logic [7:0] opnd);
        result_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= code;
        s_operand  <= opnd;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        execute_op(code, opnd, want);
        due_results.push_back(want);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_decimal_mode(input logic v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        dec_en = v;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_every_op();
        send_idle_pct = 29;
        recv_idle_pct = 83;
        for (int c = OP_ADC; c <= OP_BEQ; c++)
            send_item(6'(c), OPERAND_CORNERS[c % 5]);
        send_item(FIRST_UNUSED_OP, 8'hFF);
        send_item(LAST_UNUSED_OP, 8'h00);
    endtask

    task automatic test_decimal_and_stack();
        send_item(OP_SED, 8'h00);
        send_item(OP_CLC, 8'h00);
        send_item(OP_LDA, 8'h99);
        send_item(OP_ADC, 8'h01);
        send_item(OP_ADC, 8'h0F);
        send_item(OP_ADC, 8'hFF);
        send_item(OP_SEC, 8'h00);
        send_item(OP_SBC, 8'h01);
        send_item(OP_CLC, 8'h00);
        send_item(OP_SBC, 8'h99);
        send_item(OP_SBC, 8'hFA);
        send_item(OP_PHP, 8'h00);
        send_item(OP_PLP, 8'hFF);
        send_item(OP_PLP, 8'h00);
        send_item(OP_LDX, 8'h00);
        send_item(OP_TXS, 8'h00);
        send_item(OP_PHA, 8'h00);
        send_item(OP_PLA, 8'h42);
        send_item(OP_LDX, 8'hFF);
        send_item(OP_TXS, 8'h00);
        send_item(OP_PLA, 8'h00);
        send_item(OP_CLD, 8'h00);
        send_item(OP_ADC, 8'h99);
    endtask

    task automatic test_random_ops(input int count, input int send_pct, input int recv_pct);
        logic [5:0] code;
        logic [7:0] opnd;
        int         pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            pick = $urandom_range(99);
            opnd = 8'($urandom);
            if (pick < 6) begin
                code = 6'($urandom_range(LAST_UNUSED_OP, FIRST_UNUSED_OP));
            end else if (pick < 32) begin
                code = pick[0] ? OP_ADC : OP_SBC;
                if (pick < 20)
                    opnd = {4'($urandom_range(9, 0)), 4'($urandom_range(9, 0))};
            end else begin
                code = 6'($urandom_range(OP_BEQ, OP_ADC));
            end
            if ($urandom_range(9) == 0)
                opnd = pick[1] ? 8'hFF : 8'h00;
            send_item(code, opnd);
        end
    endtask

    // hold the output for a long stretch while the sender keeps offering
    task automatic test_receiver_hold();
        s_valid <= 1'b0;
        @(posedge aclk);
        stall_cycles_left = 150;
        @(negedge aclk);
        test_random_ops(40, 0, 0);
    endtask

    always @(negedge aclk) begin
        if (stall_cycles_left > 0) begin
            m_ready <= 1'b0;
            stall_cycles_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_write_data, m_write_enable, m_stack_slot, m_status_out, m_branch_taken};
            if (due_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: wd=%02h we=%0b slot=%02h p=%02h br=%0b",
                             got.write_data, got.write_enable, got.stack_slot,
                             got.status_out, got.branch_taken);
            end else begin
                want = due_results.pop_front();
                results_checked++;
                if (got.write_data !== want.write_data
                        || got.write_enable !== want.write_enable
                        || got.stack_slot !== want.stack_slot
                        || got.status_out !== want.status_out
                        || got.branch_taken !== want.branch_taken) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result %0d mismatch:", results_checked);
                        $display("  expected wd=%02h we=%0b slot=%02h p=%02h br=%0b",
                                 want.write_data, want.write_enable, want.stack_slot,
                                 want.status_out, want.branch_taken);
                        $display("  actual   wd=%02h we=%0b slot=%02h p=%02h br=%0b",
                                 got.write_data, got.write_enable, got.stack_slot,
                                 got.status_out, got.branch_taken);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("run did not finish in time");
        $display("[cpu_8bit_execute_stage] ERROR");
        $finish;
    end

    initial begin
        arch   = '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET, p: STATUS_RESET};
        dec_en = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_decimal_mode(1'b0);
        test_every_op();
        set_decimal_mode(1'b1);
        test_decimal_and_stack();
        set_decimal_mode(1'b0);
        test_random_ops(400, 29, 83);
        set_decimal_mode(1'b1);
        test_random_ops(400, 83, 29);
        test_receiver_hold();
        test_random_ops(400, 0, 0);
        wait_idle();
        repeat (10) @(negedge aclk);

        $display("%0d items: every operation and unused codes, decimal mode off and on,",
                 items_sent);
        $display("idle sender and receiver, long output hold; %0d results checked, %0d bad",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("[cpu_8bit_execute_stage] OK");
        else
            $display("[cpu_8bit_execute_stage] ERROR");
        $finish;
    end

endmodule

### files.f
hdl/cpu8ex_pkg.sv
hdl/cpu8ex_alu.sv
hdl/cpu_8bit_execute_stage.sv
dv/testbench.sv
